// ===== rtl/core/dsc_pkg.sv =====
// Shared types, constants and register codes of the depth sphere crop block.
package dsc_pkg;

    // Frame size limits.
    localparam int DSC_MAX_ROWS = 512;
    localparam int DSC_MAX_COLS = 512;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_ROWS = 2'd0;
    localparam logic [1:0] CFG_FRAME_COLS = 2'd1;
    localparam logic [1:0] CFG_NOSE_DEPTH = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Register reset values.
    localparam logic [9:0]  ROWS_RESET = 10'd424;
    localparam logic [9:0]  COLS_RESET = 10'd512;
    localparam logic [16:0] NOSE_UNKNOWN = 17'h1FFFF;

    // Radius arithmetic: the radius is RADIUS_NUM / nose depth.
    localparam logic [15:0] RADIUS_NUM = 16'd42000;
    localparam logic [31:0] BASE_RSQ   = 32'd4900;
    localparam logic [31:0] SAT_RSQ    = 32'hFFFF_FFFF;
    localparam logic [18:0] FACE_MIN   = 19'd100;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_RSQ,
        ST_RLD,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_FIN
    } t_state;

    // Operand selection of the shared squarer.
    typedef enum logic [1:0] {
        MUL_DR,
        MUL_DC,
        MUL_DZ,
        MUL_QUOT
    } t_mul_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     rad_base;
        logic     rad_sat;
        logic     div_start;
        t_mul_sel mul_sel;
        logic     rad_load;
        logic     acc_first;
        logic     acc_add;
        logic     finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_start;
        logic nose_unknown;
        logic nose_zero;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/depth_sphere_crop_unit.sv =====
// Top level of the depth sphere crop block: controller and datapath.
// A pixel is taken only while the controller is idle, so a new pixel waits until the last one's result is
// registered; the pace is set by the single shared squarer that forms the three squared offsets in turn.
// The first pixel of a frame with a known, nonzero nose depth first runs the bit-serial radius
// divider and one more squaring; a full, stalled result register waits.
// Synchronous active-low reset: register defaults, radius squared 4900, position zero, no result.
module depth_sphere_crop_unit
    import dsc_pkg::*;
#(
    parameter int MAX_ROWS = DSC_MAX_ROWS,
    parameter int MAX_COLS = DSC_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_depth,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_depth_out,
    output logic                  o_kept,
    output logic                  o_frame_end,
    output logic [18:0]           o_kept_total,
    output logic                  o_face_found
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    dsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    dsc_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_depth      (i_depth),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_depth_out  (o_depth_out),
        .o_kept       (o_kept),
        .o_frame_end  (o_frame_end),
        .o_kept_total (o_kept_total),
        .o_face_found (o_face_found)
    );

endmodule

// ===== rtl/core/dsc_div.sv =====
// Restoring divider that works out the crop radius one quotient bit per cycle.
module dsc_div
    import dsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_divisor,
    output logic [15:0] o_quot,
    output logic        o_done
);

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_quot, n_quot;
    logic [17:0] rem_sh;
    logic [17:0] diff;

    // One shift and trial subtract per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quot[15]};
        diff   = rem_sh - {1'b0, i_divisor};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        o_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = RADIUS_NUM;
        end else if (r_busy) begin
            if (!diff[17]) begin
                n_rem  = diff[16:0];
                n_quot = {r_quot[14:0], 1'b1};
            end else begin
                n_rem  = rem_sh[16:0];
                n_quot = {r_quot[14:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    // Control state is reset; the working registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

// ===== rtl/core/dsc_ctrl.sv =====
// Controller state machine that sequences the radius work at frame start and the distance work for each beat.
module dsc_ctrl
    import dsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.frame_start && !i_stat.nose_unknown && !i_stat.nose_zero) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_SQ0;
                    end
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_RSQ;
                end
            end
            ST_RSQ:  n_state = ST_RLD;
            ST_RLD:  n_state = ST_SQ0;
            ST_SQ0:  n_state = ST_SQ1;
            ST_SQ1:  n_state = ST_SQ2;
            ST_SQ2:  n_state = ST_SQ3;
            ST_SQ3:  n_state = ST_FIN;
            ST_FIN: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_DR;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_stat.frame_start) begin
                        if (i_stat.nose_unknown) begin
                            o_cmd.rad_base = 1'b1;
                        end else if (i_stat.nose_zero) begin
                            o_cmd.rad_sat = 1'b1;
                        end else begin
                            o_cmd.div_start = 1'b1;
                        end
                    end
                end
            end
            ST_RSQ:  o_cmd.mul_sel = MUL_QUOT;
            ST_RLD:  o_cmd.rad_load = 1'b1;
            ST_SQ0:  o_cmd.mul_sel = MUL_DR;
            ST_SQ1: begin
                o_cmd.mul_sel   = MUL_DC;
                o_cmd.acc_first = 1'b1;
            end
            ST_SQ2: begin
                o_cmd.mul_sel = MUL_DZ;
                o_cmd.acc_add = 1'b1;
            end
            ST_SQ3:  o_cmd.acc_add = 1'b1;
            ST_FIN:  o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/dsc_dp.sv =====
// Datapath: registers, position counters, shared squarer, accumulator and result register.
module dsc_dp
    import dsc_pkg::*;
#(
    parameter int MAX_ROWS = DSC_MAX_ROWS,
    parameter int MAX_COLS = DSC_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [15:0]           i_depth,
    input  logic                  i_out_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic [15:0]           o_depth_out,
    output logic                  o_kept,
    output logic                  o_frame_end,
    output logic [18:0]           o_kept_total,
    output logic                  o_face_found
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int MW0 = (RW + 2 > 18) ? RW + 2 : 18;
    localparam int MW = (CW + 2 > MW0) ? CW + 2 : MW0;
    localparam int AW = 2 * MW + 2;

    // Configuration registers.
    logic [9:0]  r_frame_rows;
    logic [9:0]  r_frame_cols;
    logic [16:0] r_nose;

    // Frame state.
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [18:0]   r_kept;
    logic [31:0]   r_rsq;

    // Working registers of one beat.
    logic [15:0]          r_depth;
    logic signed [MW-1:0] r_dr, r_dc, r_dz;
    logic [2*MW-1:0]      r_prod;
    logic [AW-1:0]        r_acc;

    // Result register.
    logic        r_out_valid;
    logic [15:0] r_depth_out;
    logic        r_kept_o;
    logic        r_frame_end;
    logic [18:0] r_kept_total;
    logic        r_face_found;

    logic [RW:0]          rows, row_inc;
    logic [CW:0]          cols, col_inc;
    logic [RW+1:0]        dr_n;
    logic [CW+1:0]        dc_n;
    logic [17:0]          dz_n;
    logic [16:0]          nose_mag;
    logic [15:0]          quot;
    logic signed [MW-1:0] mul_op;
    logic signed [2*MW-1:0] sq;
    logic                 in_sphere;
    logic                 last;
    logic [18:0]          kept_new;

    // Frame size clamped to 1..MAX.
    always_comb begin
        if (32'(r_frame_rows) > MAX_ROWS) begin
            rows = (RW + 1)'(MAX_ROWS);
        end else if (r_frame_rows == 10'd0) begin
            rows = (RW + 1)'(1);
        end else begin
            rows = (RW + 1)'(r_frame_rows);
        end
        if (32'(r_frame_cols) > MAX_COLS) begin
            cols = (CW + 1)'(MAX_COLS);
        end else if (r_frame_cols == 10'd0) begin
            cols = (CW + 1)'(1);
        end else begin
            cols = (CW + 1)'(r_frame_cols);
        end
    end

    // Offsets from the frame center and from the nose depth.
    assign dr_n = {2'b00, r_row} - {2'b00, rows[RW:1]};
    assign dc_n = {2'b00, r_col} - {2'b00, cols[CW:1]};
    assign dz_n = {2'b00, i_depth} - {r_nose[16], r_nose};

    // Magnitude of the nose depth for the radius division.
    assign nose_mag = r_nose[16] ? (~r_nose + 17'd1) : r_nose;

    dsc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (nose_mag),
        .o_quot    (quot),
        .o_done    (o_stat.div_done)
    );

    // Shared squarer with a registered product.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DR:   mul_op = r_dr;
            MUL_DC:   mul_op = r_dc;
            MUL_DZ:   mul_op = r_dz;
            MUL_QUOT: mul_op = $signed(MW'(quot));
            default:  mul_op = r_dr;
        endcase
        sq = mul_op * mul_op;
    end

    // Inside test, kept count and raster position advance.
    always_comb begin
        in_sphere = r_acc <= AW'(r_rsq);
        kept_new  = r_kept + {18'd0, in_sphere};
        row_inc   = {1'b0, r_row} + (RW + 1)'(1);
        col_inc   = {1'b0, r_col} + (CW + 1)'(1);
        last      = (col_inc >= cols) && (row_inc >= rows);
    end

    assign o_stat.frame_start  = (r_row == '0) && (r_col == '0);
    assign o_stat.nose_unknown = (r_nose == NOSE_UNKNOWN);
    assign o_stat.nose_zero    = (r_nose == 17'd0);
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

    // Configuration writes and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= ROWS_RESET;
            r_frame_cols <= COLS_RESET;
            r_nose       <= NOSE_UNKNOWN;
            r_row        <= '0;
            r_col        <= '0;
            r_kept       <= '0;
            r_rsq        <= BASE_RSQ;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data[9:0];
                    CFG_FRAME_COLS: r_frame_cols <= i_cfg_data[9:0];
                    CFG_NOSE_DEPTH: r_nose       <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_cmd.rad_base) begin
                r_rsq <= BASE_RSQ;
            end else if (i_cmd.rad_sat) begin
                r_rsq <= SAT_RSQ;
            end else if (i_cmd.rad_load) begin
                r_rsq <= r_prod[31:0];
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (col_inc >= cols) begin
                    r_col <= '0;
                    if (row_inc >= rows) begin
                        r_row <= '0;
                    end else begin
                        r_row <= row_inc[RW-1:0];
                    end
                end else begin
                    r_col <= col_inc[CW-1:0];
                end
                r_kept <= last ? 19'd0 : kept_new;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Beat capture, squares, accumulation and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_depth <= i_depth;
            r_dr    <= MW'($signed(dr_n));
            r_dc    <= MW'($signed(dc_n));
            r_dz    <= MW'($signed(dz_n));
        end
        r_prod <= sq;
        if (i_cmd.acc_first) begin
            r_acc <= AW'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (i_cmd.finish) begin
            r_depth_out  <= in_sphere ? r_depth : 16'd0;
            r_kept_o     <= in_sphere;
            r_frame_end  <= last;
            r_kept_total <= last ? kept_new : 19'd0;
            r_face_found <= last && (kept_new > FACE_MIN);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_depth_out  = r_depth_out;
    assign o_kept       = r_kept_o;
    assign o_frame_end  = r_frame_end;
    assign o_kept_total = r_kept_total;
    assign o_face_found = r_face_found;

endmodule
